// ===== rtl/core/mf3_pkg.sv =====
// Shared types and constants for the 3x3 median filter.
`timescale 1ns / 1ps

package mf3_pkg;

    localparam int WIDTH_BITS    = 11;
    localparam int HEIGHT_BITS   = 12;
    localparam int CFG_DATA_BITS = 12;
    localparam int NEIGHBOURS    = 9;
    localparam int MEDIAN_SLOT   = 4;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 12'd480;

    typedef enum logic
    {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

endpackage

// ===== rtl/core/median_filter_3x3.sv =====
// Streaming 3x3 median filter with line stores, window and sorting network.
// A result passes through line store stage, window, partial sort and output register.
// Throughput: one pixel per cycle; each line store takes one read and one write a cycle.
// A held output stalls the input once three results and a pixel are waiting.
// Border pixels produce no output transaction.
// Reset: counters clear, width 640, height 480, window zero; the line stores
// are not cleared and hold undefined data until written.
`timescale 1ns / 1ps

module median_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  cfg_index_t                    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [PIXEL_BITS-1:0]         pixel,
    input  logic                          frame_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [PIXEL_BITS-1:0]         median,
    output logic [HEIGHT_BITS-1:0]        out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]  out_col,
    output logic                          frame_last
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int CMP_BITS = (COL_BITS + 1 > WIDTH_BITS) ? COL_BITS + 1 : WIDTH_BITS;

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef pix_t pix_arr_t [NEIGHBOURS];

    function automatic pix_arr_t cswap(pix_arr_t v, int a, int b);
        pix_arr_t r;
        r = v;
        if (v[a] > v[b])
        begin
            r[a] = v[b];
            r[b] = v[a];
        end
        return r;
    endfunction

    function automatic pix_arr_t sort_front(pix_arr_t v);
        pix_arr_t p;
        p = v;
        p = cswap(p, 1, 2); p = cswap(p, 4, 5); p = cswap(p, 7, 8);
        p = cswap(p, 0, 1); p = cswap(p, 3, 4); p = cswap(p, 6, 7);
        p = cswap(p, 1, 2); p = cswap(p, 4, 5); p = cswap(p, 7, 8);
        return p;
    endfunction

    function automatic pix_t sort_back(pix_arr_t v);
        pix_arr_t p;
        p = v;
        p = cswap(p, 0, 3); p = cswap(p, 5, 8); p = cswap(p, 4, 7);
        p = cswap(p, 3, 6); p = cswap(p, 1, 4); p = cswap(p, 2, 5);
        p = cswap(p, 4, 7); p = cswap(p, 4, 2); p = cswap(p, 6, 4);
        p = cswap(p, 4, 2);
        return p[MEDIAN_SLOT];
    endfunction

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [COL_BITS-1:0]    col_count_reg, col_count_next;
    logic [HEIGHT_BITS-1:0] row_count_reg, row_count_next;

    pix_t upper_mem [MAX_WIDTH];
    pix_t middle_mem [MAX_WIDTH];
    pix_t up_rd_reg, mid_rd_reg;
    logic fwd_reg;
    pix_t fwd_up_reg, fwd_mid_reg;

    logic                   s1_valid_reg;
    pix_t                   s1_px_reg;
    logic [COL_BITS-1:0]    s1_col_reg;
    logic [HEIGHT_BITS-1:0] s1_row_reg;
    logic                   s1_last_reg;
    logic                   s1_emit_reg;

    pix_arr_t               window_reg;
    logic                   s2_valid_reg;
    logic [COL_BITS-1:0]    s2_col_reg;
    logic [HEIGHT_BITS-1:0] s2_row_reg;
    logic                   s2_last_reg;

    pix_arr_t               part_reg;
    logic                   s3_valid_reg;
    logic [COL_BITS-1:0]    s3_col_reg;
    logic [HEIGHT_BITS-1:0] s3_row_reg;
    logic                   s3_last_reg;

    logic                   out_valid_reg;
    pix_t                   median_reg;
    logic [HEIGHT_BITS-1:0] out_row_reg;
    logic [COL_BITS-1:0]    out_col_reg;
    logic                   frame_last_reg;

    logic                   in_fire, s1_fire, s2_adv, s3_adv, out_load_ok;
    logic [COL_BITS-1:0]    col_cur;
    logic [HEIGHT_BITS-1:0] row_cur;
    logic [CMP_BITS-1:0]    width_ext, w_eff, col_step;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic [HEIGHT_BITS:0]   row_step;
    logic                   col_wrap, row_wrap, last_cur, emit_cur;
    pix_t                   up_eff, mid_eff;

    assign out_load_ok = !out_valid_reg || out_ready;
    assign s3_adv      = !s3_valid_reg || out_load_ok;
    assign s2_adv      = !s2_valid_reg || s3_adv;
    assign s1_fire     = s1_valid_reg && s2_adv;
    assign in_ready    = !s1_valid_reg || s2_adv;
    assign in_fire     = in_valid && in_ready;

    assign up_eff  = fwd_reg ? fwd_up_reg : up_rd_reg;
    assign mid_eff = fwd_reg ? fwd_mid_reg : mid_rd_reg;

    always_comb
    begin
        col_cur   = frame_start ? '0 : col_count_reg;
        row_cur   = frame_start ? '0 : row_count_reg;
        width_ext = CMP_BITS'(width_reg);
        if (width_ext > CMP_BITS'(MAX_WIDTH))
            w_eff = CMP_BITS'(MAX_WIDTH);
        else if (width_ext < CMP_BITS'(3))
            w_eff = CMP_BITS'(3);
        else
            w_eff = width_ext;
        h_eff    = (height_reg < HEIGHT_BITS'(3)) ? HEIGHT_BITS'(3) : height_reg;
        col_step = CMP_BITS'(col_cur) + CMP_BITS'(1);
        row_step = {1'b0, row_cur} + (HEIGHT_BITS + 1)'(1);
        col_wrap = col_step >= w_eff;
        row_wrap = row_step >= {1'b0, h_eff};
        last_cur = (row_cur == h_eff - HEIGHT_BITS'(1))
                   && (CMP_BITS'(col_cur) == w_eff - CMP_BITS'(1));
        emit_cur = (row_cur >= HEIGHT_BITS'(2)) && (col_cur >= COL_BITS'(2));
        if (col_wrap)
        begin
            col_count_next = '0;
            row_count_next = row_wrap ? '0 : row_step[HEIGHT_BITS-1:0];
        end
        else
        begin
            col_count_next = col_step[COL_BITS-1:0];
            row_count_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            for (int i = 0; i < NEIGHBOURS; i++)
                window_reg[i] <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_BITS-1:0];
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_BITS-1:0];
                    default:          ;
                endcase
            end

            if (in_fire)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
                fwd_reg       <= s1_fire && (col_cur == s1_col_reg);
            end

            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    window_reg[r * 3 + 0] <= window_reg[r * 3 + 1];
                    window_reg[r * 3 + 1] <= window_reg[r * 3 + 2];
                end
                window_reg[2] <= up_eff;
                window_reg[5] <= mid_eff;
                window_reg[8] <= s1_px_reg;
            end

            if (s2_adv)
                s2_valid_reg <= s1_fire && s1_emit_reg;
            if (s3_adv)
                s3_valid_reg <= s2_valid_reg;
            if (out_load_ok)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            upper_mem[s1_col_reg]  <= mid_eff;
            middle_mem[s1_col_reg] <= s1_px_reg;
        end
        if (in_fire)
        begin
            up_rd_reg  <= upper_mem[col_cur];
            mid_rd_reg <= middle_mem[col_cur];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_px_reg   <= pixel;
            s1_col_reg  <= col_cur;
            s1_row_reg  <= row_cur;
            s1_last_reg <= last_cur;
            s1_emit_reg <= emit_cur;
            fwd_up_reg  <= mid_eff;
            fwd_mid_reg <= s1_px_reg;
        end
        if (s1_fire)
        begin
            s2_col_reg  <= s1_col_reg - COL_BITS'(1);
            s2_row_reg  <= s1_row_reg - HEIGHT_BITS'(1);
            s2_last_reg <= s1_last_reg;
        end
        if (s3_adv && s2_valid_reg)
        begin
            part_reg    <= sort_front(window_reg);
            s3_col_reg  <= s2_col_reg;
            s3_row_reg  <= s2_row_reg;
            s3_last_reg <= s2_last_reg;
        end
        if (out_load_ok && s3_valid_reg)
        begin
            median_reg     <= sort_back(part_reg);
            out_col_reg    <= s3_col_reg;
            out_row_reg    <= s3_row_reg;
            frame_last_reg <= s3_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign median     = median_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_last = frame_last_reg;

    a_no_s1_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (!s1_valid_reg || s1_fire))
        else $error("pixel transaction accepted over a held line store stage");

    a_s3_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !s3_adv) |=> s3_valid_reg)
        else $error("sorting stage dropped a stalled result");

    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_row_reg != '0 && out_col_reg != '0))
        else $error("output transaction at a border position");

endmodule
